// ===== rtl/audio_delay_echo_glide_macros.svh =====
// Assertion macros shared by the checker of the delay echo block
`ifndef AUDIO_DELAY_ECHO_GLIDE_MACROS_SVH
`define AUDIO_DELAY_ECHO_GLIDE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ADEG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ADEG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/adeg_pkg.sv =====
// Package of the delay echo block: types, codes and constants
`timescale 1ns / 1ps

package adeg_pkg;

	// Store depth in samples by default
	localparam int DEF_BUFFER_DEPTH = 16384;

	// Sample width and saturation limits
	localparam int SAMPLE_W = 16;
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	// Feedback scaling: divide by 32768 toward zero
	localparam int FB_SHIFT = 15;
	localparam int FB_BIAS = 32767;

	// Width of the signed target arithmetic, enough for any allowed depth
	localparam int TGT_W = 19;

	// Configuration index width
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_PLAIN,
		MODE_FEEDBACK,
		MODE_GLITCH
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_TARGET,
		CFG_GAIN,
		CFG_PERIOD,
		CFG_OFFSET
	} cfg_idx_t;

	typedef struct packed {
		mode_t               mode;
		logic [13:0]         target_delay;
		logic [15:0]         feedback_gain;
		logic [15:0]         glide_period;
		logic signed [15:0]  glitch_offset;
	} cfg_t;

endpackage

// ===== rtl/adeg_cfg.sv =====
// Configuration register file of the delay echo block
`timescale 1ns / 1ps

module adeg_cfg
	import adeg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Writes are taken every cycle
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Decode the index and load the register; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= MODE_OFF;
			cfg_q.target_delay  <= '0;
			cfg_q.feedback_gain <= '0;
			cfg_q.glide_period  <= 16'd1;
			cfg_q.glitch_offset <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:   cfg_q.mode          <= mode_t'(cfg_data[1:0]);
				CFG_TARGET: cfg_q.target_delay  <= cfg_data[13:0];
				CFG_GAIN:   cfg_q.feedback_gain <= cfg_data;
				CFG_PERIOD: cfg_q.glide_period  <= cfg_data;
				CFG_OFFSET: cfg_q.glitch_offset <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/audio_delay_echo_glide.sv =====
// Top level of the delay echo block with delay glide and feedback
`timescale 1ns / 1ps

// Delay echo with glide. One signed 16-bit sample enters on the s_ stream
// and one result leaves on the m_ stream for every sample, in order.
// Registers are written on the cfg_ channel (index, data), taken in any cycle,
// and are meant to change only while the block is idle.
// An accepted sample is registered in stage 1 and then in the stage 2 output
// register, from which it shows on m_tvalid.
// Throughput: one sample per cycle unless stalled, set by the single read port of
// the delay store feeding a two-stage read, add and scale-and-write pipeline;
// writes still in flight are forwarded to the read side.
// Reset: arst_n clears control state and registers; then the delay store is
// swept to zero, address by address, during which s_tready stays low.
// Stall: when m_tready is low the result holds in the output register; the
// stage in front keeps taking samples until it is full, then s_tready drops.
module audio_delay_echo_glide
	import adeg_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,    // [15:0] sample_in
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,    // [15:0] sample_out
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [TGT_W-1:0] DEPTH_M1 = TGT_W'(BUFFER_DEPTH - 1);
	localparam logic [TGT_W-1:0] DEPTH_T  = TGT_W'(BUFFER_DEPTH);
	localparam logic [AW-1:0]    LAST_POS = AW'(BUFFER_DEPTH - 1);

	cfg_t cfg;

	adeg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Delay store
	logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];

	// Control state
	logic [AW-1:0] wp_q;
	logic [AW:0]   cd_q;
	logic [15:0]   phase_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Pipeline stage 1: read data present
	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       act_s1;
	logic                       fb_s1;
	logic                       zero_s1;
	logic [AW-1:0]              raddr_s1;
	logic [AW-1:0]              waddr_s1;
	logic [SAMPLE_W-1:0]        rdata_s1;

	// Pipeline stage 2: output register and store write
	logic                       v_s2;
	logic signed [SAMPLE_W-1:0] y_s2;
	logic [SAMPLE_W-1:0]        x_s2;
	logic                       we_s2;
	logic                       fb_s2;
	logic [AW-1:0]              waddr_s2;

	// Last write that reached the store
	logic                w3_v_q;
	logic [AW-1:0]       w3_addr_q;
	logic [SAMPLE_W-1:0] w3_data_q;

	logic en1, en2, in_acc, active, wr_en;
	logic signed [SAMPLE_W-1:0] x_in;
	logic [TGT_W-1:0]           td_c;
	logic signed [TGT_W-1:0]    off_x, tgt, cd_ext;
	logic [AW:0]                cd_nx;
	logic [AW+1:0]              rd_sum;
	logic [AW-1:0]              rd_addr;
	logic [15:0]                period, ph_nx;
	logic [16:0]                ph_inc;
	logic                       wp_last;
	logic [AW-1:0]              wp_nx;
	logic [SAMPLE_W-1:0]        delayed;
	logic signed [SAMPLE_W:0]   sum;
	logic signed [SAMPLE_W-1:0] y_s1;
	logic signed [32:0]         prod, prod_adj, quot;
	logic [SAMPLE_W-1:0]        wr_s2;

	// Handshake: each stage moves when the next one is empty or moving
	assign en2      = !v_s2 || m_tready;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1 && !clr_busy_q;
	assign in_acc   = s_tvalid && s_tready;
	assign active   = (cfg.mode != MODE_OFF);
	assign m_tvalid = v_s2;
	assign m_tdata  = y_s2;
	assign x_in     = $signed(s_tdata);

	// Effective target, glide step and read address
	always_comb begin
		td_c = TGT_W'(cfg.target_delay);
		if (td_c > DEPTH_M1) begin
			td_c = DEPTH_M1;
		end
		off_x = (cfg.mode == MODE_GLITCH) ? TGT_W'(cfg.glitch_offset) : '0;
		tgt   = $signed(td_c) + off_x;
		if (tgt < 0) begin
			tgt = '0;
		end else if (tgt > $signed(DEPTH_T)) begin
			tgt = $signed(DEPTH_T);
		end
		cd_ext = $signed(TGT_W'(cd_q));
		cd_nx  = cd_q;
		if (phase_q == '0) begin
			if (cd_ext < tgt) begin
				cd_nx = cd_q + (AW+1)'(1);
			end else if (cd_ext > tgt) begin
				cd_nx = cd_q - (AW+1)'(1);
			end
		end
		rd_sum = (AW+2)'(wp_q) + (AW+2)'(BUFFER_DEPTH) - (AW+2)'(cd_nx);
		if (rd_sum >= (AW+2)'(BUFFER_DEPTH)) begin
			rd_sum = rd_sum - (AW+2)'(BUFFER_DEPTH);
		end
		rd_addr = rd_sum[AW-1:0];
	end

	// Phase counter and write position advance
	always_comb begin
		period  = (cfg.glide_period == '0) ? 16'd1 : cfg.glide_period;
		ph_inc  = {1'b0, phase_q} + 17'd1;
		ph_nx   = (ph_inc >= {1'b0, period}) ? '0 : ph_inc[15:0];
		wp_last = (wp_q == LAST_POS);
		wp_nx   = wp_last ? '0 : wp_q + AW'(1);
		if (wp_last) begin
			ph_nx = '0;
		end
	end

	// Update delay, phase and position for each active item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			cd_q    <= '0;
			phase_q <= '0;
		end else if (in_acc && active) begin
			wp_q    <= wp_nx;
			cd_q    <= cd_nx;
			phase_q <= ph_nx;
		end
	end

	// Sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_POS) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// Read the delayed sample when an item enters
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_acc;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1     <= x_in;
			act_s1   <= active;
			fb_s1    <= (cfg.mode == MODE_FEEDBACK);
			zero_s1  <= (cd_nx == '0);
			raddr_s1 <= rd_addr;
			waddr_s1 <= wp_q;
		end
	end

	// Forward writes not yet seen by the read, then add and saturate (input passes unchanged when off)
	always_comb begin
		if (zero_s1) begin
			delayed = '0;
		end else if (v_s2 && we_s2 && (waddr_s2 == raddr_s1)) begin
			delayed = wr_s2;
		end else if (w3_v_q && (w3_addr_q == raddr_s1)) begin
			delayed = w3_data_q;
		end else begin
			delayed = rdata_s1;
		end
		sum = (SAMPLE_W+1)'(x_s1) + (SAMPLE_W+1)'($signed(delayed));
		if (!act_s1) begin
			y_s1 = x_s1;
		end else if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
			y_s1 = sum[SAMPLE_W] ? SAT_MIN : SAT_MAX;
		end else begin
			y_s1 = sum[SAMPLE_W-1:0];
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			y_s2     <= y_s1;
			x_s2     <= x_s1;
			we_s2    <= act_s1;
			fb_s2    <= fb_s1;
			waddr_s2 <= waddr_s1;
		end
	end

	// In feedback mode scale the output by the feedback gain, truncating toward zero; else the input is written
	always_comb begin
		prod     = $signed(y_s2) * $signed({1'b0, cfg.feedback_gain});
		prod_adj = prod + (prod[32] ? 33'(FB_BIAS) : 33'sd0);
		quot     = prod_adj >>> FB_SHIFT;
		wr_s2    = fb_s2 ? quot[SAMPLE_W-1:0] : x_s2;
	end

	assign wr_en = v_s2 && m_tready && we_s2;

	// Store write: clearing sweep or the item leaving stage 2
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[waddr_s2] <= wr_s2;
		end
	end

	// Hold the last write for the read issued at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w3_v_q <= 1'b0;
		end else if (wr_en) begin
			w3_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			w3_addr_q <= waddr_s2;
			w3_data_q <= wr_s2;
		end
	end

endmodule

// ===== rtl/adeg_checker.sv =====
// Port-level checker of the delay echo block and its bind
`timescale 1ns / 1ps
`include "audio_delay_echo_glide_macros.svh"

module adeg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result stays offered and unchanged
	`ADEG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`ADEG_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

	// The store sweep blocks input right after reset
	`ADEG_ASSERT_NOW(a_clear_blocks, !$past(arst_n), !s_tready, "item taken during store sweep")

	// A result appearing from an empty output comes from an item that passed through stage 1
	`ADEG_ASSERT_NOW(a_no_invent, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without item")

endmodule

bind audio_delay_echo_glide adeg_checker u_adeg_checker (.*);
